### sv/cltw_pkg.sv
// ----------------------------------------------------------------------------
// cltw_pkg
// Shared types and constants for the character LCD text and cursor writer.
// ----------------------------------------------------------------------------
package cltw_pkg;

    typedef enum logic [1:0] {
        OP_PUT_CHAR    = 2'd0,
        OP_SET_ADDR    = 2'd1,
        OP_SET_ROW_COL = 2'd2,
        OP_CLEAR       = 2'd3
    } op_t;

    localparam logic [1:0] CFG_ROW0_BASE = 2'd0;
    localparam logic [1:0] CFG_ROW1_BASE = 2'd1;
    localparam logic [1:0] CFG_ROW2_BASE = 2'd2;
    localparam logic [1:0] CFG_ROW3_BASE = 2'd3;

    localparam logic [6:0] ROW0_BASE_RST = 7'd0;
    localparam logic [6:0] ROW1_BASE_RST = 7'd64;
    localparam logic [6:0] ROW2_BASE_RST = 7'd16;
    localparam logic [6:0] ROW3_BASE_RST = 7'd80;

    localparam logic [7:0] SET_ADDR_CMD = 8'h80;
    localparam logic [7:0] CLEAR_CMD    = 8'h01;
    localparam logic [6:0] SEG_MASK     = 7'h70;
    localparam logic [3:0] LAST_COLUMN  = 4'd15;

    // one LCD bus write
    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } bus_write_t;

    // writes caused by one command; second is valid only when two is set
    typedef struct packed {
        logic       two;
        bus_write_t first;
        bus_write_t second;
    } cmd_result_t;

endpackage

### sv/cltw_cmd_unit.sv
// ----------------------------------------------------------------------------
// cltw_cmd_unit
// Row base registers, cursor register and command decode into bus writes.
// ----------------------------------------------------------------------------
module cltw_cmd_unit
    import cltw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_wr_data,
    input  logic        advance,
    input  op_t         operation,
    input  logic [7:0]  char_code,
    input  logic [6:0]  target_address,
    input  logic [1:0]  row,
    input  logic [3:0]  column,
    output cmd_result_t result,
    output logic [6:0]  cursor
);

    logic [6:0] row_base_reg [4];
    logic [6:0] cursor_reg;
    logic [6:0] cursor_next;
    logic [6:0] seg;
    logic [6:0] wrap_addr;
    logic [6:0] rc_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_base_reg[0] <= ROW0_BASE_RST;
            row_base_reg[1] <= ROW1_BASE_RST;
            row_base_reg[2] <= ROW2_BASE_RST;
            row_base_reg[3] <= ROW3_BASE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ROW0_BASE: row_base_reg[0] <= cfg_wr_data;
                CFG_ROW1_BASE: row_base_reg[1] <= cfg_wr_data;
                CFG_ROW2_BASE: row_base_reg[2] <= cfg_wr_data;
                CFG_ROW3_BASE: row_base_reg[3] <= cfg_wr_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= 7'd0;
        end else if (advance) begin
            cursor_reg <= cursor_next;
        end
    end

    // first matching row base wins; unmatched segment falls back to its own start
    always_comb begin
        seg = cursor_reg & SEG_MASK;
        if (seg == row_base_reg[0]) begin
            wrap_addr = row_base_reg[1];
        end else if (seg == row_base_reg[1]) begin
            wrap_addr = row_base_reg[2];
        end else if (seg == row_base_reg[2]) begin
            wrap_addr = row_base_reg[3];
        end else if (seg == row_base_reg[3]) begin
            wrap_addr = row_base_reg[0];
        end else begin
            wrap_addr = seg;
        end
    end

    assign rc_addr = row_base_reg[row] + {3'd0, column};

    always_comb begin
        result.two              = 1'b0;
        result.first.is_data    = 1'b0;
        result.first.bus_byte   = CLEAR_CMD;
        result.first.last       = 1'b1;
        result.second.is_data   = 1'b0;
        result.second.bus_byte  = SET_ADDR_CMD | {1'b0, wrap_addr};
        result.second.last      = 1'b1;
        cursor_next             = 7'd0;
        unique case (operation)
            OP_PUT_CHAR: begin
                result.first.is_data  = 1'b1;
                result.first.bus_byte = char_code;
                if (cursor_reg[3:0] == LAST_COLUMN) begin
                    result.two        = 1'b1;
                    result.first.last = 1'b0;
                    cursor_next       = wrap_addr;
                end else begin
                    cursor_next = cursor_reg + 7'd1;
                end
            end
            OP_SET_ADDR: begin
                result.first.bus_byte = SET_ADDR_CMD | {1'b0, target_address};
                cursor_next           = target_address;
            end
            OP_SET_ROW_COL: begin
                result.first.bus_byte = SET_ADDR_CMD | {1'b0, rc_addr};
                cursor_next           = rc_addr;
            end
            OP_CLEAR: begin
                result.first.bus_byte = CLEAR_CMD;
                cursor_next           = 7'd0;
            end
            default: ;
        endcase
    end

    assign cursor = cursor_reg;

endmodule

### sv/cltw_out_buf.sv
// ----------------------------------------------------------------------------
// cltw_out_buf
// Two-entry result buffer; takes one or two bus writes at once, drains one
// per transfer.
// ----------------------------------------------------------------------------
module cltw_out_buf
    import cltw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push_valid,
    input  cmd_result_t push_data,
    output logic        push_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output bus_write_t  m_data
);

    bus_write_t entry0_reg, entry0_next;
    bus_write_t entry1_reg, entry1_next;
    logic [1:0] count_reg, count_next;
    logic       pop;
    logic       push;
    logic [1:0] remain;
    bus_write_t kept;

    assign pop    = (count_reg != 2'd0) && m_ready;
    assign remain = count_reg - {1'b0, pop};
    assign kept   = pop ? entry1_reg : entry0_reg;

    assign push_ready = push_data.two ? (remain == 2'd0) : (remain <= 2'd1);
    assign push       = push_valid && push_ready;

    always_comb begin
        entry0_next = kept;
        entry1_next = entry1_reg;
        count_next  = remain;
        if (push) begin
            if (remain == 2'd0) begin
                entry0_next = push_data.first;
                entry1_next = push_data.second;
            end else begin
                entry1_next = push_data.first;
            end
            count_next = remain + (push_data.two ? 2'd2 : 2'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry0_reg <= entry0_next;
        entry1_reg <= entry1_next;
    end

    assign m_valid = (count_reg != 2'd0);
    assign m_data  = entry0_reg;

endmodule

### sv/char_lcd_text_cursor_writer.sv
// ----------------------------------------------------------------------------
// char_lcd_text_cursor_writer
// Turns text and cursor commands into character LCD instruction/data writes.
// ----------------------------------------------------------------------------
// Path: input register, then the output buffer register, to the bus write.
// Throughput: one command per cycle while m_ready keeps the buffer draining;
//   a character at a row end waits until the two-entry output buffer, draining one write per cycle, is empty.
// Reset: synchronous, active low; cursor to 0, row bases to 0/64/16/80,
//   input register and output buffer emptied.
module char_lcd_text_cursor_writer
    import cltw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [6:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [7:0] s_char_code,
    input  logic [6:0] s_target_address,
    input  logic [1:0] s_row,
    input  logic [3:0] s_column,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_is_data,
    output logic [7:0] m_bus_byte,
    output logic       m_last
);

    logic        in_valid_reg;
    op_t         op_reg;
    logic [7:0]  char_reg;
    logic [6:0]  target_reg;
    logic [1:0]  row_reg;
    logic [3:0]  column_reg;
    logic        advance;
    logic        buf_ready;
    cmd_result_t cmd_res;
    bus_write_t  out_write;
    logic [6:0]  cursor;

    assign advance = in_valid_reg && buf_ready;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg     <= op_t'(s_operation);
            char_reg   <= s_char_code;
            target_reg <= s_target_address;
            row_reg    <= s_row;
            column_reg <= s_column;
        end
    end

    cltw_cmd_unit u_cmd (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .advance        (advance),
        .operation      (op_reg),
        .char_code      (char_reg),
        .target_address (target_reg),
        .row            (row_reg),
        .column         (column_reg),
        .result         (cmd_res),
        .cursor         (cursor)
    );

    cltw_out_buf u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (in_valid_reg),
        .push_data  (cmd_res),
        .push_ready (buf_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (out_write)
    );

    assign m_is_data  = out_write.is_data;
    assign m_bus_byte = out_write.bus_byte;
    assign m_last     = out_write.last;

`ifndef SYNTHESIS
    // only the data write of a row-end character is followed by another write
    a_nonlast_is_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> m_is_data)
        else $error("non-final bus write is not a data write");

    a_clear_zeroes_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && op_reg == OP_CLEAR) |=> (cursor == 7'd0))
        else $error("cursor not zero after clear");

    a_two_writes_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && cmd_res.two) |=> (m_valid && !m_last))
        else $error("row-end character did not present its data write first");
`endif

endmodule

### dv/char_lcd_text_cursor_writer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_lcd_text_cursor_writer_test
// Self-checking bench for the LCD text/cursor writer. Commands go in on a
// valid/ready channel; the bench tracks the cursor and row bases itself and
// matches every bus write against its own prediction, in order. A directed
// run covers row ends, wrap-around and clear; random phases follow, several
// with new row base registers, some with no idling on one or both sides.
// ----------------------------------------------------------------------------
module char_lcd_text_cursor_writer_test;
    import cltw_pkg::*;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int SINK_HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT     = 1000000;

    // ------------------------------------------------------------------------
    // Tracks cursor and row bases, holds the bus writes still to come
    // ------------------------------------------------------------------------
    class lcd_write_scoreboard;
        logic [6:0]  row_base [4];
        logic [6:0]  cursor;
        bus_write_t  pending_writes [$];
        int unsigned errors;

        function new();
            row_base[CFG_ROW0_BASE] = ROW0_BASE_RST;
            row_base[CFG_ROW1_BASE] = ROW1_BASE_RST;
            row_base[CFG_ROW2_BASE] = ROW2_BASE_RST;
            row_base[CFG_ROW3_BASE] = ROW3_BASE_RST;
            cursor = '0;
            errors = 0;
        endfunction

        function void set_row_base(logic [1:0] idx, logic [6:0] value);
            row_base[idx] = value;
        endfunction

        function int unsigned pending();
            return pending_writes.size();
        endfunction

        function void note_command(op_t op, logic [7:0] ch, logic [6:0] target,
                                   logic [1:0] row, logic [3:0] col);
            logic [6:0] seg;
            logic [6:0] next_addr;
            logic [1:0] nxt;
            bit         found;
            case (op)
                OP_PUT_CHAR: begin
                    if (cursor[3:0] == LAST_COLUMN) begin
                        // row end: first matching base moves on to the next row
                        seg = cursor & SEG_MASK;
                        next_addr = seg;
                        found = 0;
                        for (int i = 0; i < 4; i++) begin
                            if (!found && seg == row_base[i]) begin
                                nxt = 2'(i + 1);
                                next_addr = row_base[nxt];
                                found = 1;
                            end
                        end
                        pending_writes.push_back(bus_write_t'{1'b1, ch, 1'b0});
                        pending_writes.push_back(
                            bus_write_t'{1'b0, SET_ADDR_CMD | {1'b0, next_addr}, 1'b1});
                        cursor = next_addr;
                    end else begin
                        pending_writes.push_back(bus_write_t'{1'b1, ch, 1'b1});
                        cursor = cursor + 7'd1;
                    end
                end
                OP_SET_ADDR: begin
                    pending_writes.push_back(
                        bus_write_t'{1'b0, SET_ADDR_CMD | {1'b0, target}, 1'b1});
                    cursor = target;
                end
                OP_SET_ROW_COL: begin
                    next_addr = row_base[row] + {3'b0, col};
                    pending_writes.push_back(
                        bus_write_t'{1'b0, SET_ADDR_CMD | {1'b0, next_addr}, 1'b1});
                    cursor = next_addr;
                end
                default: begin
                    pending_writes.push_back(bus_write_t'{1'b0, CLEAR_CMD, 1'b1});
                    cursor = '0;
                end
            endcase
        endfunction

        function void check_write(bus_write_t got);
            bus_write_t exp;
            if (pending_writes.size() == 0) begin
                $display("[%0t] unexpected bus write: is_data %0d byte 0x%02h last %0d",
                         $time, got.is_data, got.bus_byte, got.last);
                errors++;
                return;
            end
            exp = pending_writes.pop_front();
            if (got.is_data !== exp.is_data) begin
                $display("[%0t] is_data mismatch: expected %0d, actual %0d",
                         $time, exp.is_data, got.is_data);
                errors++;
            end
            if (got.bus_byte !== exp.bus_byte) begin
                $display("[%0t] bus_byte mismatch: expected 0x%02h, actual 0x%02h",
                         $time, exp.bus_byte, got.bus_byte);
                errors++;
            end
            if (got.last !== exp.last) begin
                $display("[%0t] last mismatch: expected %0d, actual %0d",
                         $time, exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = CFG_ROW0_BASE;
    logic [6:0] cfg_wr_data = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_operation = OP_CLEAR;
    logic [7:0] s_char_code = '0;
    logic [6:0] s_target_address = '0;
    logic [1:0] s_row = '0;
    logic [3:0] s_column = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_is_data;
    logic [7:0] m_bus_byte;
    logic       m_last;

    lcd_write_scoreboard sb = new();

    int unsigned sender_gap_max = 19;
    int unsigned sink_stall_max = 19;
    bit          sink_hold_req = 0;
    int unsigned cycle_count = 0;

    char_lcd_text_cursor_writer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_char_code      (s_char_code),
        .s_target_address (s_target_address),
        .s_row            (s_row),
        .s_column         (s_column),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_is_data        (m_is_data),
        .m_bus_byte       (m_bus_byte),
        .m_last           (m_last)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // input noted before output, so a same-edge result still finds its entry
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_command(op_t'(s_operation), s_char_code, s_target_address,
                                s_row, s_column);
            if (m_valid && m_ready)
                sb.check_write(bus_write_t'{m_is_data, m_bus_byte, m_last});
        end
    end

    // result side: random stall per transfer, one long hold-off on request
    initial begin
        int unsigned stall;
        forever begin
            if (sink_hold_req) begin
                m_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge aclk);
                sink_hold_req = 0;
            end
            stall = $urandom_range(sink_stall_max, 0);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    task automatic send_item(op_t op, logic [7:0] ch, logic [6:0] target,
                             logic [1:0] row, logic [3:0] col);
        int unsigned gap;
        gap = $urandom_range(sender_gap_max, 0);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_operation      <= op;
        s_char_code      <= ch;
        s_target_address <= target;
        s_row            <= row;
        s_column         <= col;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random_item();
        int unsigned pick;
        op_t         op;
        logic [6:0]  target;
        logic [3:0]  col;
        pick = $urandom_range(99, 0);
        // mostly characters so the cursor keeps reaching row ends
        if (pick < 65)      op = OP_PUT_CHAR;
        else if (pick < 77) op = OP_SET_ROW_COL;
        else if (pick < 90) op = OP_SET_ADDR;
        else                op = OP_CLEAR;
        target = 7'($urandom);
        col    = 4'($urandom);
        if ($urandom_range(1, 0) == 1) begin
            target[3:0] = 4'($urandom_range(15, 12));
            col         = 4'($urandom_range(15, 12));
        end
        send_item(op, 8'($urandom), target, 2'($urandom), col);
    endtask

    task automatic write_row_bases(logic [6:0] b0, logic [6:0] b1,
                                   logic [6:0] b2, logic [6:0] b3);
        logic [6:0] vals [4];
        logic [1:0] idx  [4];
        vals = '{b0, b1, b2, b3};
        idx  = '{CFG_ROW0_BASE, CFG_ROW1_BASE, CFG_ROW2_BASE, CFG_ROW3_BASE};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= idx[i];
            cfg_wr_data <= vals[i];
            sb.set_row_base(idx[i], vals[i]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [6:0] aligned_base();
        return {3'($urandom_range(7, 0)), 4'b0};
    endfunction

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset row bases 0/64/16/80
        send_item(OP_CLEAR,       8'h00, 7'h00, 2'd0, 4'd0);
        send_item(OP_PUT_CHAR,    8'h00, 7'h7f, 2'd3, 4'hf);
        send_item(OP_PUT_CHAR,    8'hff, 7'h00, 2'd0, 4'h0);
        send_item(OP_SET_ADDR,    8'hff, 7'h7f, 2'd0, 4'h0);
        // top address, segment matches no row: back to its own segment start
        send_item(OP_PUT_CHAR,    8'ha5, 7'h00, 2'd0, 4'h0);
        send_item(OP_SET_ADDR,    8'h00, 7'h00, 2'd3, 4'hf);
        send_item(OP_SET_ADDR,    8'h00, 7'h0f, 2'd0, 4'h0);
        send_item(OP_PUT_CHAR,    8'h41, 7'h00, 2'd0, 4'h0);
        send_item(OP_SET_ROW_COL, 8'h00, 7'h00, 2'd1, 4'hf);
        send_item(OP_PUT_CHAR,    8'h42, 7'h00, 2'd0, 4'h0);
        send_item(OP_SET_ROW_COL, 8'h00, 7'h00, 2'd2, 4'hf);
        send_item(OP_PUT_CHAR,    8'h43, 7'h00, 2'd0, 4'h0);
        // last row wraps back to row 0
        send_item(OP_SET_ROW_COL, 8'h00, 7'h00, 2'd3, 4'hf);
        send_item(OP_PUT_CHAR,    8'h44, 7'h00, 2'd0, 4'h0);
        send_item(OP_SET_ADDR,    8'h00, 7'h2f, 2'd0, 4'h0);
        send_item(OP_PUT_CHAR,    8'h45, 7'h00, 2'd0, 4'h0);
        send_item(OP_SET_ROW_COL, 8'h00, 7'h00, 2'd0, 4'h0);
        send_item(OP_PUT_CHAR,    8'h7e, 7'h55, 2'd1, 4'h5);
        send_item(OP_PUT_CHAR,    8'h80, 7'h2a, 2'd2, 4'ha);
        send_item(OP_SET_ROW_COL, 8'h00, 7'h00, 2'd0, 4'hf);
        send_item(OP_PUT_CHAR,    8'h5a, 7'h00, 2'd0, 4'h0);
        send_item(OP_CLEAR,       8'hff, 7'h7f, 2'd3, 4'hf);
        send_item(OP_PUT_CHAR,    8'h31, 7'h00, 2'd0, 4'h0);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: ;
                1: write_row_bases(7'h7f, 7'h7f, 7'h7f, 7'h7f);
                2: write_row_bases(7'h00, 7'h00, 7'h00, 7'h00);
                3: write_row_bases(7'd0, 7'd64, 7'd20, 7'd84);
                4: write_row_bases(7'($urandom), 7'($urandom), 7'($urandom),
                                   7'($urandom));
                5: write_row_bases(ROW0_BASE_RST, ROW1_BASE_RST, ROW2_BASE_RST,
                                   ROW3_BASE_RST);
                default: write_row_bases(aligned_base(), aligned_base(),
                                         aligned_base(), aligned_base());
            endcase
            sender_gap_max = (p == 3 || p == 6) ? 0 : 19;
            sink_stall_max = (p == 2 || p == 6) ? 0 : 19;
            // back-to-back commands against a stalled bus fill the block up
            if (p == 3)
                sink_hold_req = 1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_item();
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
sv/cltw_pkg.sv
sv/cltw_cmd_unit.sv
sv/cltw_out_buf.sv
sv/char_lcd_text_cursor_writer.sv
dv/char_lcd_text_cursor_writer_test.sv
